### hw/rtl/stos_pkg.sv
// Shared types for the sorted table occurrence search block.
`timescale 1ns / 1ps

package stos_pkg;

   // Field widths of the request and response transactions.
   localparam int IndexWidth = 8;
   localparam int ValueWidth = 32;
   localparam int CountWidth = 9;

   // Request kinds carried on req_tuser.
   localparam logic OpWrite  = 1'b0;
   localparam logic OpSearch = 1'b1;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;     // load the key and open both search ranges
      logic run;       // perform one interleaved probe step
      logic phase;     // 0: left search reads, right compares; 1: the reverse
      logic wr_en;     // store one table entry from the request
      logic load_rsp;  // capture the search answer into the response register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic search_done;  // both ranges closed and no read outstanding
   } status_type;

endpackage

### hw/rtl/stos_dpath.sv
// Datapath: table memory, two binary search contexts and the response register.
`timescale 1ns / 1ps

module stos_dpath #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  stos_pkg::cmd_type   cmd,
   output stos_pkg::status_type status,
   input  logic [71:0]         req_tdata,
   input  logic                csr_wr_en,
   input  logic [stos_pkg::CountWidth-1:0] csr_wr_data,
   output logic                rsp_found,
   output logic [stos_pkg::IndexWidth-1:0] rsp_first,
   output logic [stos_pkg::IndexWidth-1:0] rsp_last
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   // Request fields.
   logic        [stos_pkg::IndexWidth-1:0] req_index;
   logic signed [stos_pkg::ValueWidth-1:0] req_value;
   logic signed [stos_pkg::ValueWidth-1:0] req_key;

   assign req_index = req_tdata[7:0];
   assign req_value = req_tdata[39:8];
   assign req_key   = req_tdata[71:40];

   // Entry count register.
   logic [stos_pkg::CountWidth-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   // Used entry count, saturated to the table depth.
   logic [CW-1:0] used_n;

   always_comb begin
      if (32'(count_ff) > 32'(TABLE_DEPTH)) begin
         used_n = CW'(TABLE_DEPTH);
      end else begin
         used_n = CW'(count_ff);
      end
   end

   // Table memory with a registered read port.
   logic signed [stos_pkg::ValueWidth-1:0] table_mem [TABLE_DEPTH];
   logic signed [stos_pkg::ValueWidth-1:0] rd_data_ff;
   logic                                   mem_wr;
   logic [AW-1:0]                          wr_addr;
   logic                                   rd_en;
   logic [AW-1:0]                          rd_addr;

   assign mem_wr  = cmd.wr_en && (32'(req_index) < 32'(TABLE_DEPTH));
   assign wr_addr = AW'(req_index);

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         table_mem[wr_addr] <= req_value;
      end
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   // Search key register.
   logic signed [stos_pkg::ValueWidth-1:0] key_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_ff <= req_key;
      end
   end

   // Search contexts: 0 leans left, 1 leans right. The range is [lo, hiex).
   logic [CW-1:0] lo_ff   [2];
   logic [CW-1:0] hiex_ff [2];
   logic [AW-1:0] mid_ff  [2];
   logic [AW-1:0] hit_ff  [2];
   logic          hitv_ff [2];
   logic          pend_ff [2];
   logic [CW-1:0] mid     [2];
   logic          open_rg [2];

   // Midpoint and open test for each context.
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         mid[k]     = lo_ff[k] + ((hiex_ff[k] - lo_ff[k] - CW'(1)) >> 1);
         open_rg[k] = lo_ff[k] < hiex_ff[k];
      end
   end

   // The reading context is chosen by the phase.
   assign rd_addr = cmd.phase ? mid[1][AW-1:0] : mid[0][AW-1:0];
   assign rd_en   = cmd.run && (cmd.phase ? open_rg[1] : open_rg[0]);

   // Compare of the entry read in the previous cycle against the key.
   logic key_eq;
   logic key_gt;

   assign key_eq = (rd_data_ff == key_ff);
   assign key_gt = (key_ff > rd_data_ff);

   // Context update: one context issues a read while the other compares.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 2; k++) begin
            pend_ff[k] <= 1'b0;
            hitv_ff[k] <= 1'b0;
         end
      end else if (cmd.start) begin
         for (int k = 0; k < 2; k++) begin
            lo_ff[k]   <= '0;
            hiex_ff[k] <= used_n;
            pend_ff[k] <= 1'b0;
            hitv_ff[k] <= 1'b0;
         end
      end else if (cmd.run) begin
         for (int k = 0; k < 2; k++) begin
            if (cmd.phase == 1'(k)) begin
               pend_ff[k] <= open_rg[k];
               mid_ff[k]  <= mid[k][AW-1:0];
            end else if (pend_ff[k]) begin
               pend_ff[k] <= 1'b0;
               if (key_eq) begin
                  hitv_ff[k] <= 1'b1;
                  hit_ff[k]  <= mid_ff[k];
                  if (k == 0) begin
                     hiex_ff[k] <= CW'(mid_ff[k]);
                  end else begin
                     lo_ff[k] <= CW'(mid_ff[k]) + CW'(1);
                  end
               end else if (key_gt) begin
                  lo_ff[k] <= CW'(mid_ff[k]) + CW'(1);
               end else begin
                  hiex_ff[k] <= CW'(mid_ff[k]);
               end
            end
         end
      end
   end

   assign status.search_done = !open_rg[0] && !open_rg[1] && !pend_ff[0] && !pend_ff[1];

   // Response payload register.
   logic                          found_ff;
   logic [stos_pkg::IndexWidth-1:0] first_ff;
   logic [stos_pkg::IndexWidth-1:0] last_ff;
   logic                          found_in;

   assign found_in = hitv_ff[0] && hitv_ff[1];

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         found_ff <= found_in;
         first_ff <= found_in ? stos_pkg::IndexWidth'(hit_ff[0]) : '0;
         last_ff  <= found_in ? stos_pkg::IndexWidth'(hit_ff[1]) : '0;
      end
   end

   assign rsp_found = found_ff;
   assign rsp_first = first_ff;
   assign rsp_last  = last_ff;

endmodule

### hw/rtl/stos_ctrl.sv
// Controller: sequences request transactions, the probe phases and the response.
`timescale 1ns / 1ps

module stos_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output stos_pkg::cmd_type    cmd,
   input  stos_pkg::status_type status
);

   stos_pkg::state_type state_ff;
   stos_pkg::state_type state_in;
   logic                phase_ff;
   logic                phase_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;

   // State, phase and response valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stos_pkg::ST_IDLE;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      req_tready   = 1'b0;
      cmd          = '0;
      cmd.phase    = phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         stos_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == stos_pkg::OpSearch) begin
                  cmd.start = 1'b1;
                  phase_in  = 1'b0;
                  state_in  = stos_pkg::ST_RUN;
               end else begin
                  cmd.wr_en = 1'b1;
               end
            end
         end
         stos_pkg::ST_RUN: begin
            if (status.search_done) begin
               state_in = stos_pkg::ST_RESP;
            end else begin
               cmd.run  = 1'b1;
               phase_in = !phase_ff;
            end
         end
         stos_pkg::ST_RESP: begin
            // Wait until the response register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = stos_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = stos_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

### hw/rtl/sorted_table_occurrence_search.sv
// Top level of the sorted table occurrence search block.
//
// Channel  Direction  Signals                        Contents
// req      in         tvalid/tready/tdata/tuser      write entry or search key
// rsp      out        tvalid/tready/tdata/tuser      found flag, first and last index
// csr      in         wr_en/wr_data                  entry_count
//
// A write transaction stores one entry and is taken in the idle state. No new request is
// accepted while a search runs, until it has loaded the response register. The two
// searches share the single registered read port of the table and alternate on it.
// Reset clears the count and the controller; table contents stay undefined until
// written. A waiting response does not block new requests; a search only stalls at its
// end until the response register frees.
`timescale 1ns / 1ps

module sorted_table_occurrence_search #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   // Request: tdata = index[7:0], entry_value[39:8], search_key[71:40]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,
   // Request: tuser = opcode
   input  logic        req_tuser,
   // Response: tdata = first_index[7:0], last_index[15:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   // Response: tuser = found
   output logic        rsp_tuser,
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data
);

   stos_pkg::cmd_type    cmd;
   stos_pkg::status_type status;
   logic                 found;
   logic [7:0]           first_index;
   logic [7:0]           last_index;

   // Control sequencer.
   stos_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // Table and search datapath.
   stos_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_found   (found),
      .rsp_first   (first_index),
      .rsp_last    (last_index)
   );

   assign rsp_tdata = {last_index, first_index};
   assign rsp_tuser = found;

endmodule

### tb/sorted_table_occurrence_search_tb.sv
// Testbench for the sorted table occurrence search block: scoreboard, stimulus and checks.
`timescale 1ns / 1ps

module sorted_table_occurrence_search_tb;

   localparam int TableDepth  = 256;
   localparam int ItemTarget  = 850;
   localparam int DrainCycles = 40;
   localparam int StallLimit  = 3000;
   localparam int LongHold    = 400;
   localparam int ReportLimit = 50;
   localparam logic signed [stos_pkg::ValueWidth-1:0] MinValue = 32'sh8000_0000;
   localparam logic signed [stos_pkg::ValueWidth-1:0] MaxValue = 32'sh7FFF_FFFF;

   // One search answer as the block reports it.
   typedef struct packed {
      logic                            found;
      logic [stos_pkg::IndexWidth-1:0] first_index;
      logic [stos_pkg::IndexWidth-1:0] last_index;
   } search_answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // Fields from bit 0 up: index[7:0], entry_value[39:8], search_key[71:40].
   logic [71:0] req_tdata = '0;
   // Fields from bit 0 up: opcode.
   logic        req_tuser = stos_pkg::OpWrite;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // Fields from bit 0 up: first_index[7:0], last_index[15:8].
   logic [15:0] rsp_tdata;
   // Fields from bit 0 up: found.
   logic        rsp_tuser;
   logic        csr_wr_en = 1'b0;
   logic [stos_pkg::CountWidth-1:0] csr_wr_data = '0;

   // Mirror of the block state and the answers still owed by it.
   logic signed [stos_pkg::ValueWidth-1:0] entry_mirror [TableDepth];
   int                entry_count_mirror = 0;
   search_answer_type pending_answers [$];

   int req_max_gap     = 18;
   int rsp_max_stall   = 18;
   int hold_off_cycles = 0;
   int mismatch_count  = 0;
   int items_sent      = 0;
   int searches_sent   = 0;
   int hits_predicted  = 0;
   int csr_writes      = 0;

   sorted_table_occurrence_search #(
      .TABLE_DEPTH(TableDepth)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial forever #6 clock = ~clock;

   // Number of entries that a search covers after saturation.
   function automatic int used_entries();
      return (entry_count_mirror > TableDepth) ? TableDepth : entry_count_mirror;
   endfunction

   // Binary search over the mirror; lean_right keeps narrowing right after a match.
   function automatic int find_occurrence(input logic signed [stos_pkg::ValueWidth-1:0] key,
                                          input int used, input bit lean_right);
      int lo = 0;
      int hi = used - 1;
      int hit = -1;
      int mid;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (entry_mirror[mid] == key) begin
            hit = mid;
            if (lean_right) lo = mid + 1;
            else hi = mid - 1;
         end else if (key > entry_mirror[mid]) begin
            lo = mid + 1;
         end else begin
            hi = mid - 1;
         end
      end
      return hit;
   endfunction

   function automatic search_answer_type predict_search(
         input logic signed [stos_pkg::ValueWidth-1:0] key);
      int first = find_occurrence(key, used_entries(), 1'b0);
      int last  = find_occurrence(key, used_entries(), 1'b1);
      search_answer_type answer;
      answer.found       = (first >= 0) && (last >= 0);
      answer.first_index = answer.found ? stos_pkg::IndexWidth'(first) : '0;
      answer.last_index  = answer.found ? stos_pkg::IndexWidth'(last) : '0;
      return answer;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= ReportLimit)
         $display("MISMATCH %s: got %0d, expected %0d at %0t ns", what, got, want, $time);
   endtask

   // Offers one request transaction after a random gap and updates the mirror once accepted.
   task automatic send_request(input logic op, input logic [stos_pkg::IndexWidth-1:0] idx,
                               input logic signed [stos_pkg::ValueWidth-1:0] value,
                               input logic signed [stos_pkg::ValueWidth-1:0] key);
      int gap = $urandom_range(0, req_max_gap);
      search_answer_type answer;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {key, value, idx};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (op == stos_pkg::OpWrite) begin
         entry_mirror[idx] = value;
      end else begin
         answer = predict_search(key);
         pending_answers.push_back(answer);
         searches_sent++;
         if (answer.found) hits_predicted++;
      end
   endtask

   task automatic search_for(input logic signed [stos_pkg::ValueWidth-1:0] key);
      send_request(stos_pkg::OpSearch, stos_pkg::IndexWidth'($urandom), $urandom, key);
   endtask

   // Changes the count only once the block has gone quiet.
   task automatic set_entry_count(input int count);
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= stos_pkg::CountWidth'(count);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      entry_count_mirror = count;
      csr_writes++;
   endtask

   // Rewrites entries 0 to n-1 as an ascending run; a spread run goes from the
   // smallest to the largest value, a tight one is dense with duplicates.
   task automatic write_sorted_run(input int n, input bit spread);
      longint value;
      int k;
      value = spread ? longint'(MinValue) : longint'(int'($urandom));
      for (k = 0; k < n; k++) begin
         if (spread && k == n - 1) value = MaxValue;
         send_request(stos_pkg::OpWrite, stos_pkg::IndexWidth'(k),
                      value[stos_pkg::ValueWidth-1:0], $urandom);
         if ($urandom_range(0, 2) != 0)
            value += spread ? $urandom_range(1, 1 << 25) : $urandom_range(1, 2);
         if (value > longint'(MaxValue)) value = MaxValue;
      end
   endtask

   // Keys mostly hit the used entries, the rest land beside them or anywhere.
   function automatic logic signed [stos_pkg::ValueWidth-1:0] pick_key(input int used);
      int pick = $urandom_range(0, 9);
      logic signed [stos_pkg::ValueWidth-1:0] base;
      if (used == 0) return $urandom;
      base = entry_mirror[$urandom_range(0, used - 1)];
      case (pick)
         6: return base + 1;
         7: return base - 1;
         8: return $urandom_range(0, 1) ? MaxValue : MinValue;
         9: return $urandom;
         default: return base;
      endcase
   endfunction

   // Searches right after reset see an empty table.
   task automatic test_empty_table();
      search_for(MinValue);
      search_for(MaxValue);
      search_for(0);
   endtask

   task automatic test_fill_table();
      write_sorted_run(TableDepth, 1'b1);
   endtask

   // Table ends, duplicates, gaps, tiny and saturated counts, and one out-of-order entry.
   task automatic test_search_extremes();
      int dup = 5;
      int k;
      logic signed [stos_pkg::ValueWidth-1:0] saved;
      for (k = TableDepth - 2; k >= 0; k--)
         if (entry_mirror[k] == entry_mirror[k + 1]) dup = k;
      set_entry_count(TableDepth);
      search_for(entry_mirror[0]);
      search_for(entry_mirror[TableDepth - 1]);
      search_for(entry_mirror[dup]);
      search_for(entry_mirror[dup] + 1);
      search_for(entry_mirror[TableDepth / 2] - 1);
      set_entry_count(1);
      search_for(entry_mirror[0]);
      search_for(entry_mirror[1]);
      set_entry_count(2);
      search_for(entry_mirror[1]);
      set_entry_count(511);
      search_for(entry_mirror[TableDepth - 1]);
      search_for(MaxValue);
      set_entry_count(300);
      search_for(entry_mirror[TableDepth / 2]);
      set_entry_count(TableDepth);
      saved = entry_mirror[100];
      send_request(stos_pkg::OpWrite, 8'd100, MaxValue, $urandom);
      search_for(MaxValue);
      search_for(saved);
      send_request(stos_pkg::OpWrite, 8'd100, saved, $urandom);
   endtask

   // The receiver stops for a long stretch while searches keep coming.
   task automatic test_response_backpressure();
      set_entry_count(TableDepth);
      req_max_gap     = 0;
      hold_off_cycles = LongHold;
      repeat (12) search_for(pick_key(used_entries()));
      req_max_gap = 18;
   endtask

   task automatic test_random_phases();
      int count;
      bit quiet;
      while (items_sent < ItemTarget) begin
         quiet = ($urandom_range(0, 3) == 0);
         req_max_gap   = quiet ? 0 : 18;
         rsp_max_stall = quiet ? 0 : 18;
         case ($urandom_range(0, 9))
            0: count = 0;
            1: count = 1;
            2: count = 2;
            7: count = TableDepth;
            8: count = $urandom_range(0, 1) ? TableDepth - 1 : $urandom_range(65, 254);
            9: count = $urandom_range(TableDepth + 1, 511);
            default: count = $urandom_range(3, 64);
         endcase
         set_entry_count(count);
         if (count >= 1 && count <= 64 && $urandom_range(0, 4) != 0) begin
            write_sorted_run(count, $urandom_range(0, 1));
         end else if (used_entries() > 0 && $urandom_range(0, 3) == 0) begin
            // Break the order with a few stray values.
            repeat ($urandom_range(1, 3))
               send_request(stos_pkg::OpWrite,
                            stos_pkg::IndexWidth'($urandom_range(0, used_entries() - 1)),
                            $urandom, $urandom);
         end
         repeat ($urandom_range(8, 24)) search_for(pick_key(used_entries()));
      end
   endtask

   // Response side: random stalls, then each transaction is checked in order.
   initial begin : answer_checker
      int stall;
      search_answer_type want;
      while (reset) @(posedge clock);
      forever begin
         stall = $urandom_range(0, rsp_max_stall);
         if (hold_off_cycles > 0) begin
            stall = hold_off_cycles;
            hold_off_cycles = 0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (pending_answers.size() == 0) begin
            report_mismatch("response with no search pending", rsp_tdata, 0);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tuser !== want.found)
               report_mismatch("found", rsp_tuser, want.found);
            if (rsp_tdata[7:0] !== want.first_index)
               report_mismatch("first_index", rsp_tdata[7:0], want.first_index);
            if (rsp_tdata[15:8] !== want.last_index)
               report_mismatch("last_index", rsp_tdata[15:8], want.last_index);
         end
      end
   end

   // Ends the run when no transaction moves for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= StallLimit) begin
            $display("Timeout: no transaction for %0d cycles", StallLimit);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin : main_sequence
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_fill_table();
      test_search_extremes();
      test_response_backpressure();
      test_random_phases();

      // Let every owed answer arrive, then give the block time to settle.
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (pending_answers.size() != 0)
         report_mismatch("searches left without a response", pending_answers.size(), 0);
      $display("Covered %0d requests: %0d searches (%0d expected hits), %0d count settings.",
               items_sent, searches_sent, hits_predicted, csr_writes);
      $display("Mismatches found: %0d", mismatch_count);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### filelist.f
hw/rtl/stos_pkg.sv
hw/rtl/stos_dpath.sv
hw/rtl/stos_ctrl.sv
hw/rtl/sorted_table_occurrence_search.sv
tb/sorted_table_occurrence_search_tb.sv
